// ----- rtl/core/rbb_pkg.sv -----
package rbb_pkg;

  // Storage size and the longest read run.
  localparam int DEPTH     = 4096;
  localparam int MAX_BURST = 64;

  // Field widths.
  localparam int LEN_W   = 13;
  localparam int PTR_W   = 12;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 2;
  localparam int TYPE_W  = 3;
  localparam int BURST_W = $clog2(MAX_BURST + 1);

  // Request codes.
  localparam logic [TYPE_W-1:0] REQ_WR_START = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_WR_BYTE  = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_READ     = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_SKIP     = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_PEEK     = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_DATA  = 2'd2;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [LEN_W-1:0]  req_len;
    logic              must_fit;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  offset;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  done_len;
    logic [BYTE_W-1:0] read_byte;
    logic              read_last;
    logic [PTR_W-1:0]  run_position;
    logic [LEN_W-1:0]  fill_count;
    logic [LEN_W-1:0]  space_left;
  } out_word_t;

endpackage

// ----- rtl/core/rbb_ram.sv -----
module rbb_ram #(
  parameter int WIDTH = 8,
  parameter int WORDS = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(WORDS)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(WORDS)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/ring_byte_buffer_unit.sv -----
// Write start, write byte, skip and peek give their result word, registered, in the cycle after
// acceptance, and can be accepted back to back. A read's bytes pass the store's read register
// and then the output register, one per cycle while no length is written; busy is high, and no
// request is taken, while they stream out, due to the store latency, and drops with the last byte.
// Reset (rst_n low, synchronous) empties the buffer and sets the length in use to the full
// store; store contents are not cleared. Result words cannot be stalled by the receiver.
module ring_byte_buffer_unit
  import rbb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_word_t         in_word,
  output logic             out_strobe,
  output out_word_t        out_word,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  // The controller is idle except while a read run streams bytes out of the store.
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t state_r, state_nxt;

  // Length in use and the ring pointers. Pointers always stay below the length.
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [PTR_W-1:0]   rp_r, rp_nxt;
  logic [PTR_W-1:0]   wp_r, wp_nxt;
  logic [LEN_W-1:0]   held_r, held_nxt;

  // Remaining bytes of the open write burst: those to store and those to drop.
  logic [LEN_W-1:0]   store_left_r, store_left_nxt;
  logic [LEN_W-1:0]   drop_left_r, drop_left_nxt;

  // Read run bookkeeping: reads still to issue, words still to emit, run length,
  // and a flag that the store returns a byte this cycle.
  logic [BURST_W-1:0] rd_issue_r, rd_issue_nxt;
  logic [BURST_W-1:0] rd_emit_r, rd_emit_nxt;
  logic [BURST_W-1:0] rd_len_r, rd_len_nxt;
  logic               pend_r, pend_nxt;

  logic               out_strobe_r, out_strobe_nxt;
  out_word_t          out_r, out_nxt;

  // Store port signals.
  logic               ram_we;
  logic               ram_re;
  logic [BYTE_W-1:0]  ram_rdata;

  logic               accept;
  logic [LEN_W-1:0]   space;
  logic [LEN_W-1:0]   cfg_len;
  logic [LEN_W:0]     wp_inc;
  logic [LEN_W:0]     rp_inc;
  logic [PTR_W-1:0]   wp_wrap;
  logic [PTR_W-1:0]   rp_wrap;
  logic [LEN_W-1:0]   skip_n;
  logic [PTR_W-1:0]   skip_rp;
  logic [PTR_W-1:0]   peek_pos;
  logic [LEN_W-1:0]   peek_run;
  logic [LEN_W-1:0]   rd_sat;
  logic [LEN_W-1:0]   rd_n;
  logic [LEN_W-1:0]   grant;
  logic               can_store;

  // Adds n to a pointer and wraps once at the length in use. A single subtraction brings the
  // sum back into range when n is at most the length; peek may pass a larger, unused offset.
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                input logic [LEN_W-1:0] n,
                                                input logic [LEN_W-1:0] len);
    logic [LEN_W:0] s;
    s = {2'b00, p} + {1'b0, n};
    if (s >= {1'b0, len}) begin
      s = s - {1'b0, len};
    end
    return s[PTR_W-1:0];
  endfunction

  assign accept = start && !busy;
  assign space  = len_r - held_r;

  // A length write of zero means one byte; anything above the store size is clamped.
  always_comb begin
    cfg_len = cfg_wdata;
    if (cfg_wdata == '0) begin
      cfg_len = LEN_W'(1);
    end else if (cfg_wdata > LEN_W'(DEPTH)) begin
      cfg_len = LEN_W'(DEPTH);
    end
  end

  // Single-step pointer advance for byte writes and byte reads.
  assign wp_inc  = {2'b00, wp_r} + {{LEN_W{1'b0}}, 1'b1};
  assign rp_inc  = {2'b00, rp_r} + {{LEN_W{1'b0}}, 1'b1};
  assign wp_wrap = (wp_inc >= {1'b0, len_r}) ? '0 : wp_inc[PTR_W-1:0];
  assign rp_wrap = (rp_inc >= {1'b0, len_r}) ? '0 : rp_inc[PTR_W-1:0];

  // Skip moves the read point by the offset, clamped to what is held.
  assign skip_n  = (in_word.offset > held_r) ? held_r : in_word.offset;
  assign skip_rp = wrap_add(rp_r, skip_n, len_r);

  // Peek: the run from the offset position ends at the write point, or at the end of
  // the ring when the held bytes wrap around. A full buffer with the position on the
  // write point also counts as wrapped, since every byte is held.
  assign peek_pos = wrap_add(rp_r, in_word.offset, len_r);
  always_comb begin
    if ((peek_pos > wp_r) || ((peek_pos == wp_r) && (in_word.offset < held_r))) begin
      peek_run = len_r - {1'b0, peek_pos};
    end else begin
      peek_run = {1'b0, wp_r} - {1'b0, peek_pos};
    end
  end

  // Read length: saturated at the burst limit, then at the held count.
  assign rd_sat = (in_word.req_len > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST)
                                                         : in_word.req_len;
  assign rd_n   = (rd_sat > held_r) ? held_r : rd_sat;

  assign grant     = (in_word.req_len > space) ? space : in_word.req_len;
  assign can_store = (store_left_r != '0) && (held_r < len_r);

  // The store is written only by an accepted write byte that falls in the granted
  // part of a burst. Reads always come from the read point; the controller is busy
  // during a run, so reads and writes never meet in the same cycle.
  assign ram_we = accept && !cfg_we && (in_word.req_type == REQ_WR_BYTE) && can_store;
  assign ram_re = (accept && !cfg_we && (in_word.req_type == REQ_READ) && (rd_n != '0))
               || ((state_r == ST_READ) && (rd_issue_r != '0));

  rbb_ram #(
    .WIDTH (BYTE_W),
    .WORDS (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_word.data_byte),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    rp_nxt         = rp_r;
    wp_nxt         = wp_r;
    held_nxt       = held_r;
    store_left_nxt = store_left_r;
    drop_left_nxt  = drop_left_r;
    rd_issue_nxt   = rd_issue_r;
    rd_emit_nxt    = rd_emit_r;
    rd_len_nxt     = rd_len_r;
    pend_nxt       = 1'b0;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;

    // Every result word carries zero in the fields its request does not use.
    out_nxt.status       = STAT_OK;
    out_nxt.done_len     = '0;
    out_nxt.read_byte    = '0;
    out_nxt.read_last    = 1'b0;
    out_nxt.run_position = '0;

    if (cfg_we) begin
      // A new length empties the buffer and closes any burst.
      len_nxt        = cfg_len;
      rp_nxt         = '0;
      wp_nxt         = '0;
      held_nxt       = '0;
      store_left_nxt = '0;
      drop_left_nxt  = '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            out_strobe_nxt = 1'b1;
            case (in_word.req_type)
              REQ_WR_START: begin
                // A new burst abandons whatever is left of the previous one.
                store_left_nxt = '0;
                drop_left_nxt  = '0;
                if (in_word.req_len == '0) begin
                  out_nxt.status = STAT_OK;
                end else if ((space == '0) || ((in_word.req_len > space) && in_word.must_fit)) begin
                  drop_left_nxt  = in_word.req_len;
                  out_nxt.status = STAT_NO_SPACE;
                end else begin
                  store_left_nxt   = grant;
                  drop_left_nxt    = in_word.req_len - grant;
                  out_nxt.done_len = grant;
                end
              end
              REQ_WR_BYTE: begin
                if (can_store) begin
                  wp_nxt           = wp_wrap;
                  held_nxt         = held_r + LEN_W'(1);
                  store_left_nxt   = store_left_r - LEN_W'(1);
                  out_nxt.done_len = LEN_W'(1);
                end else begin
                  // Stray bytes and bytes beyond the grant are dropped.
                  if (store_left_r != '0) begin
                    store_left_nxt = store_left_r - LEN_W'(1);
                  end else if (drop_left_r != '0) begin
                    drop_left_nxt = drop_left_r - LEN_W'(1);
                  end
                  out_nxt.status = STAT_NO_SPACE;
                end
              end
              REQ_READ: begin
                if (rd_n == '0) begin
                  out_nxt.status = STAT_NO_DATA;
                end else begin
                  // The first byte is fetched now; the result word for this
                  // acceptance is withheld and the run's words follow instead.
                  out_strobe_nxt = 1'b0;
                  held_nxt       = held_r - rd_n;
                  rp_nxt         = rp_wrap;
                  rd_len_nxt     = rd_n[BURST_W-1:0];
                  rd_emit_nxt    = rd_n[BURST_W-1:0];
                  rd_issue_nxt   = rd_n[BURST_W-1:0] - BURST_W'(1);
                  pend_nxt       = 1'b1;
                  state_nxt      = ST_READ;
                end
              end
              REQ_SKIP: begin
                held_nxt         = held_r - skip_n;
                rp_nxt           = skip_rp;
                out_nxt.done_len = skip_n;
              end
              REQ_PEEK: begin
                if (in_word.offset > held_r) begin
                  out_nxt.status = STAT_NO_DATA;
                end else begin
                  out_nxt.done_len     = peek_run;
                  out_nxt.run_position = peek_pos;
                end
              end
              default: begin
                // Unused request codes give no result word.
                out_strobe_nxt = 1'b0;
              end
            endcase
          end
        end
        ST_READ: begin
          // Issue the next fetch while the byte fetched last cycle goes out.
          if (rd_issue_r != '0) begin
            rp_nxt       = rp_wrap;
            rd_issue_nxt = rd_issue_r - BURST_W'(1);
            pend_nxt     = 1'b1;
          end
          if (pend_r) begin
            out_strobe_nxt    = 1'b1;
            out_nxt.done_len  = LEN_W'(rd_len_r);
            out_nxt.read_byte = ram_rdata;
            out_nxt.read_last = (rd_emit_r == BURST_W'(1));
            rd_emit_nxt       = rd_emit_r - BURST_W'(1);
            if (rd_emit_r == BURST_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end

    // The counts shown are those after the step.
    out_nxt.fill_count = held_nxt;
    out_nxt.space_left = len_nxt - held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      len_r        <= LEN_W'(DEPTH);
      rp_r         <= '0;
      wp_r         <= '0;
      held_r       <= '0;
      store_left_r <= '0;
      drop_left_r  <= '0;
      rd_issue_r   <= '0;
      rd_emit_r    <= '0;
      rd_len_r     <= '0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      len_r        <= len_nxt;
      rp_r         <= rp_nxt;
      wp_r         <= wp_nxt;
      held_r       <= held_nxt;
      store_left_r <= store_left_nxt;
      drop_left_r  <= drop_left_nxt;
      rd_issue_r   <= rd_issue_nxt;
      rd_emit_r    <= rd_emit_nxt;
      rd_len_r     <= rd_len_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    out_r <= out_nxt;
  end

  assign busy       = (state_r == ST_READ);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_r;

endmodule

// ----- rtl/core/rbb_checker.sv -----
module rbb_checker
  import rbb_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_word_t  in_word,
  input logic      out_strobe,
  input out_word_t out_word,
  input logic      cfg_we
);

  // Held plus free bytes is the length in use, which lies between one and the store size.
  a_counts_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (({1'b0, out_word.fill_count} + {1'b0, out_word.space_left})
                    <= (LEN_W + 1)'(DEPTH))
                && (({1'b0, out_word.fill_count} + {1'b0, out_word.space_left}) != '0))
    else $error("fill count plus space left out of range");

  // The last byte of a read run is only ever delivered with status ok.
  a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.read_last) |-> (out_word.status == STAT_OK))
    else $error("last read byte with a bad status");

  // The last word of a read run is shown when the block is free again.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.read_last) |-> !busy)
    else $error("busy still high on the last read byte");

  // An accepted write start, write byte, skip or peek gives its result word next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !cfg_we &&
     ((in_word.req_type == REQ_WR_START) || (in_word.req_type == REQ_WR_BYTE) ||
      (in_word.req_type == REQ_SKIP) || (in_word.req_type == REQ_PEEK)))
    |=> (out_strobe && !busy))
    else $error("missing result word after an accepted request");

endmodule

bind ring_byte_buffer_unit rbb_checker u_rbb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_word    (in_word),
  .out_strobe (out_strobe),
  .out_word   (out_word),
  .cfg_we     (cfg_we)
);
